FILE: rtl/eps_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eps_pkg
// shared types, codes and tables of the equalizer preset string parser
// ----------------------------------------------------------------------------
package eps_pkg;

	localparam int unsigned FIXED_BAND_COUNT_DEF = 10;

	// field widths
	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned TYPE_W  = 3;
	localparam int unsigned FREQ_W  = 25;
	localparam int unsigned GAIN_W  = 21;
	localparam int unsigned Q_W     = 17;
	localparam int unsigned ACC_W   = 27;
	localparam int unsigned VAL_W   = ACC_W + 1;
	localparam int unsigned FIDX_W  = 4;
	localparam int unsigned TDATA_W = 72;
	localparam int unsigned CFG_IDX_W = 1;

	// output queue
	localparam int unsigned OQ_DEPTH = 4;
	localparam int unsigned OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int unsigned OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	// configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_Q = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_FIXED_Q   = 1'b1;
	localparam logic [Q_W-1:0] DEFAULT_Q_RST = 17'd707;
	localparam logic [Q_W-1:0] FIXED_Q_RST   = 17'd1410;

	// characters
	localparam logic [CHAR_W-1:0] CH_A     = 8'h41;
	localparam logic [CHAR_W-1:0] CH_F     = 8'h46;
	localparam logic [CHAR_W-1:0] CH_G     = 8'h47;
	localparam logic [CHAR_W-1:0] CH_H     = 8'h48;
	localparam logic [CHAR_W-1:0] CH_I     = 8'h49;
	localparam logic [CHAR_W-1:0] CH_L     = 8'h4C;
	localparam logic [CHAR_W-1:0] CH_M     = 8'h4D;
	localparam logic [CHAR_W-1:0] CH_P     = 8'h50;
	localparam logic [CHAR_W-1:0] CH_Q     = 8'h51;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;

	// band types
	localparam logic [TYPE_W-1:0] BT_PEAK         = 3'd0;
	localparam logic [TYPE_W-1:0] BT_LOW_SHELF    = 3'd1;
	localparam logic [TYPE_W-1:0] BT_HIGH_SHELF   = 3'd2;
	localparam logic [TYPE_W-1:0] BT_LOW_SHELF_C  = 3'd3;
	localparam logic [TYPE_W-1:0] BT_HIGH_SHELF_C = 3'd4;

	typedef enum logic [3:0] {
		PH_EXPECT_A  = 4'd0,
		PH_NUM_START = 4'd1,
		PH_NUM_BODY  = 4'd2,
		PH_TAG       = 4'd3,
		PH_SKIP      = 4'd4
	} phase_t;

	typedef enum logic [2:0] {
		TG_PREAMP = 3'd0,
		TG_FGAIN  = 3'd1,
		TG_FREQ   = 3'd2,
		TG_GAIN   = 3'd3,
		TG_Q      = 3'd4
	} target_t;

	typedef enum logic [1:0] {
		KIND_PREAMP = 2'd0,
		KIND_BAND   = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t                     kind;
		logic [TYPE_W-1:0]         band_type;
		logic [FREQ_W-1:0]         freq;
		logic signed [GAIN_W-1:0]  gain;
		logic [Q_W-1:0]            q;
		logic                      accepted;
		logic                      last;
	} result_t;

	// results of one character: an optional band/preamp result, then an optional status
	typedef struct packed {
		logic    a_valid;
		result_t a;
		logic    b_valid;
		result_t b;
	} pair_t;

	// fixed band frequencies in milli-hertz, indexes past the table take the last entry
	function automatic logic [FREQ_W-1:0] fixed_freq(input logic [FIDX_W-1:0] idx);
		logic [FREQ_W-1:0] f;
		case (idx)
			4'd0:    f = 25'd31000;
			4'd1:    f = 25'd62000;
			4'd2:    f = 25'd125000;
			4'd3:    f = 25'd250000;
			4'd4:    f = 25'd500000;
			4'd5:    f = 25'd1000000;
			4'd6:    f = 25'd2000000;
			4'd7:    f = 25'd4000000;
			4'd8:    f = 25'd8000000;
			default: f = 25'd16000000;
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

FILE: rtl/eps_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eps_core
// parser state and per-character update, one character per enabled cycle
// ----------------------------------------------------------------------------
module eps_core #(
	parameter int unsigned FIXED_BAND_COUNT = eps_pkg::FIXED_BAND_COUNT_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        step,
	input  wire logic [eps_pkg::CHAR_W-1:0]  char_code,
	input  wire logic                        line_end,
	input  wire logic [eps_pkg::Q_W-1:0]     default_q,
	input  wire logic [eps_pkg::Q_W-1:0]     fixed_q,
	output eps_pkg::pair_t                   results
);
	import eps_pkg::*;

	localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
	localparam int unsigned INT_W = ACC_W + 4;

	typedef struct packed {
		target_t            target;
		logic [ACC_W-1:0]   acc;
		logic [1:0]         frac;
		logic               dot;
		logic               bad;
		logic               neg;
	} num_t;

	typedef struct packed {
		logic                      emit;
		result_t                   res;
		logic [FREQ_W-1:0]         pfreq;
		logic signed [GAIN_W-1:0]  pgain;
		logic                      band;
		logic                      start;
		target_t                   start_tg;
	} fin_t;

	function automatic num_t start_num(input target_t tg);
		num_t n;
		n = '0;
		n.target = tg;
		return n;
	endfunction

	function automatic logic signed [VAL_W-1:0] num_value(input num_t n);
		logic signed [VAL_W-1:0] m;
		m = $signed({1'b0, n.acc});
		if (n.bad)
			return '0;
		return n.neg ? -m : m;
	endfunction

	function automatic logic signed [GAIN_W-1:0] clamp_wide(input logic signed [VAL_W-1:0] v);
		if (v < -28'sd1000000)
			return -21'sd1000000;
		if (v > 28'sd1000000)
			return 21'sd1000000;
		return v[GAIN_W-1:0];
	endfunction

	function automatic logic signed [GAIN_W-1:0] clamp_gain(input logic signed [VAL_W-1:0] v);
		if (v < -28'sd40000)
			return -21'sd40000;
		if (v > 28'sd40000)
			return 21'sd40000;
		return v[GAIN_W-1:0];
	endfunction

	function automatic logic [FREQ_W-1:0] clamp_freq(input logic signed [VAL_W-1:0] v);
		if (v < 28'sd1000)
			return 25'd1000;
		if (v > 28'sd24000000)
			return 25'd24000000;
		return v[FREQ_W-1:0];
	endfunction

	function automatic logic [Q_W-1:0] clamp_q(input logic signed [VAL_W-1:0] v);
		if (v < 28'sd50)
			return 17'd50;
		if (v > 28'sd100000)
			return 17'd100000;
		return v[Q_W-1:0];
	endfunction

	// completes n; G/Q after freq and Q after gain open the next number
	function automatic fin_t finish(
		input num_t                      n,
		input logic                      has_term,
		input logic [CHAR_W-1:0]         c,
		input logic [TYPE_W-1:0]         ptype,
		input logic [FREQ_W-1:0]         pfreq,
		input logic signed [GAIN_W-1:0]  pgain,
		input logic [Q_W-1:0]            dq,
		input logic [Q_W-1:0]            fq
	);
		logic signed [VAL_W-1:0] v;
		logic signed [VAL_W-1:0] dqv;
		logic [Q_W-1:0]          qsel;
		fin_t f;
		v   = num_value(n);
		dqv = $signed({{(VAL_W-Q_W){1'b0}}, dq});
		f = '0;
		f.pfreq = pfreq;
		f.pgain = pgain;
		f.start_tg = TG_PREAMP;
		qsel = clamp_q(dqv);
		case (n.target)
			TG_PREAMP: begin
				f.emit = 1'b1;
				f.res.kind = KIND_PREAMP;
				f.res.gain = clamp_wide(v);
			end
			TG_FGAIN: begin
				f.emit = 1'b1;
				f.band = 1'b1;
				f.res.kind = KIND_BAND;
				f.res.band_type = ptype;
				f.res.freq = pfreq;
				f.res.gain = clamp_wide(v);
				f.res.q = fq;
			end
			TG_FREQ: begin
				f.pfreq = clamp_freq(v);
				if (has_term && c == CH_G) begin
					f.start = 1'b1;
					f.start_tg = TG_GAIN;
				end else if (has_term && c == CH_Q) begin
					f.start = 1'b1;
					f.start_tg = TG_Q;
				end
			end
			TG_GAIN: begin
				f.pgain = clamp_gain(v);
				if (has_term && c == CH_Q) begin
					f.start = 1'b1;
					f.start_tg = TG_Q;
				end
			end
			default: begin
				qsel = clamp_q(v);
			end
		endcase
		// parametric band closes unless another field follows
		if ((n.target == TG_FREQ || n.target == TG_GAIN || n.target == TG_Q) && !f.start) begin
			f.emit = 1'b1;
			f.band = 1'b1;
			f.res.kind = KIND_BAND;
			f.res.band_type = ptype;
			f.res.freq = f.pfreq;
			f.res.gain = f.pgain;
			f.res.q = qsel;
		end
		return f;
	endfunction

	phase_t                    phase_q, phase_d;
	num_t                      num_q, num_d;
	logic [TYPE_W-1:0]         ptype_q, ptype_d;
	logic [FREQ_W-1:0]         pfreq_q, pfreq_d;
	logic signed [GAIN_W-1:0]  pgain_q, pgain_d;
	logic [FIDX_W-1:0]         fidx_q, fidx_d;
	logic                      anyb_q, anyb_d;
	logic                      rej_q, rej_d;

	fin_t                      fin1, fin2;
	logic                      tag_now;
	logic                      line_ok;

	logic                      is_sign, is_digit, is_dot;
	logic [3:0]                digit;
	logic [INT_W-1:0]          int_sum;
	logic [ACC_W:0]            frac_sum;
	logic [6:0]                frac_w;
	logic [ACC_W-1:0]          digit_acc;

	// character class and accumulator step
	always_comb begin
		is_sign  = (phase_q == PH_NUM_START) && (char_code == CH_MINUS || char_code == CH_PLUS);
		is_digit = (char_code >= CH_0) && (char_code <= CH_9);
		is_dot   = (char_code == CH_DOT);
		digit    = 4'(char_code - CH_0);
		int_sum  = ({4'b0, num_q.acc} << 3) + ({4'b0, num_q.acc} << 1)
			+ INT_W'(digit) * INT_W'(1000);
		case (num_q.frac)
			2'd0:    frac_w = 7'd100;
			2'd1:    frac_w = 7'd10;
			default: frac_w = 7'd1;
		endcase
		frac_sum = {1'b0, num_q.acc} + (ACC_W+1)'(digit) * (ACC_W+1)'(frac_w);
		if (!num_q.dot)
			digit_acc = (int_sum > INT_W'(ACC_MAX)) ? ACC_MAX : int_sum[ACC_W-1:0];
		else if (num_q.frac != 2'd3)
			digit_acc = frac_sum[ACC_W] ? ACC_MAX : frac_sum[ACC_W-1:0];
		else
			digit_acc = num_q.acc;
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		num_d   = num_q;
		ptype_d = ptype_q;
		pfreq_d = pfreq_q;
		pgain_d = pgain_q;
		fidx_d  = fidx_q;
		anyb_d  = anyb_q;
		rej_d   = rej_q;
		fin1    = '0;
		fin2    = '0;
		tag_now = 1'b0;
		line_ok = 1'b0;

		case (phase_q)
			PH_EXPECT_A: begin
				if (char_code == CH_A) begin
					num_d = start_num(TG_PREAMP);
					phase_d = PH_NUM_START;
				end else begin
					rej_d = 1'b1;
					phase_d = PH_SKIP;
				end
			end
			PH_NUM_START, PH_NUM_BODY: begin
				if (is_sign) begin
					num_d.neg = (char_code == CH_MINUS);
					phase_d = PH_NUM_BODY;
				end else if (is_digit) begin
					num_d.acc = digit_acc;
					if (num_q.dot && num_q.frac != 2'd3)
						num_d.frac = num_q.frac + 2'd1;
					phase_d = PH_NUM_BODY;
				end else if (is_dot) begin
					num_d.bad = num_q.bad | num_q.dot;
					num_d.dot = 1'b1;
					phase_d = PH_NUM_BODY;
				end else begin
					fin1 = finish(num_q, 1'b1, char_code, ptype_q, pfreq_q, pgain_q,
						default_q, fixed_q);
					pfreq_d = fin1.pfreq;
					pgain_d = fin1.pgain;
					if (fin1.band)
						anyb_d = 1'b1;
					if (fin1.start) begin
						num_d = start_num(fin1.start_tg);
						phase_d = PH_NUM_START;
					end else begin
						phase_d = PH_TAG;
						tag_now = 1'b1;
					end
				end
			end
			PH_TAG: begin
				tag_now = 1'b1;
			end
			default: begin
			end
		endcase

		if (tag_now) begin
			case (char_code)
				CH_F: begin
					if (fidx_q >= FIDX_W'(FIXED_BAND_COUNT)) begin
						phase_d = PH_SKIP;
					end else begin
						ptype_d = BT_PEAK;
						pfreq_d = fixed_freq(fidx_q);
						fidx_d = fidx_q + 1'b1;
						num_d = start_num(TG_FGAIN);
						phase_d = PH_NUM_START;
					end
				end
				CH_P, CH_L, CH_H, CH_M, CH_I: begin
					case (char_code)
						CH_L:    ptype_d = BT_LOW_SHELF;
						CH_H:    ptype_d = BT_HIGH_SHELF;
						CH_M:    ptype_d = BT_LOW_SHELF_C;
						CH_I:    ptype_d = BT_HIGH_SHELF_C;
						default: ptype_d = BT_PEAK;
					endcase
					pgain_d = '0;
					num_d = start_num(TG_FREQ);
					phase_d = PH_NUM_START;
				end
				default: begin
				end
			endcase
		end

		if (line_end) begin
			if (phase_d == PH_NUM_START || phase_d == PH_NUM_BODY) begin
				fin2 = finish(num_d, 1'b0, char_code, ptype_d, pfreq_d, pgain_d,
					default_q, fixed_q);
				if (fin2.band)
					anyb_d = 1'b1;
			end
			line_ok = anyb_d && !rej_d;
			phase_d = PH_EXPECT_A;
			num_d   = '0;
			ptype_d = '0;
			pfreq_d = '0;
			pgain_d = '0;
			fidx_d  = '0;
			anyb_d  = 1'b0;
			rej_d   = 1'b0;
		end
	end

	// results; a band opened and closed by the last character is dropped
	// when a number result already precedes the status
	always_comb begin
		results = '0;
		results.a_valid = step && (fin1.emit || fin2.emit);
		results.a = fin1.emit ? fin1.res : fin2.res;
		results.b_valid = step && line_end;
		results.b.kind = KIND_STATUS;
		results.b.accepted = line_ok;
		results.b.last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_EXPECT_A;
			num_q   <= '0;
			ptype_q <= '0;
			pfreq_q <= '0;
			pgain_q <= '0;
			fidx_q  <= '0;
			anyb_q  <= 1'b0;
			rej_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_d;
			num_q   <= num_d;
			ptype_q <= ptype_d;
			pfreq_q <= pfreq_d;
			pgain_q <= pgain_d;
			fidx_q  <= fidx_d;
			anyb_q  <= anyb_d;
			rej_q   <= rej_d;
		end
	end

endmodule
`default_nettype wire

FILE: rtl/eq_preset_string_parser.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eq_preset_string_parser
// character-serial parser of equalizer record lines into preamp, band and
// status transactions
// ----------------------------------------------------------------------------
// One character enters per transaction on the slave side (tlast marks the
// last character of a line) and is held in an input register; once the
// queue can take two results, the parser core updates its state with it and
// drops zero, one or two results into a four-entry output queue, from whose
// head the master side is driven. A character that closes a number gives at
// most one preamp or band result, and the last character of a line adds the
// status transaction (tlast high). The parser takes one character per cycle
// for as long as the queue has two free entries; the master port drains one
// result per cycle, so the sustained rate is one character per cycle
// whenever results come no faster than one per cycle and the sink does not
// stall. default_q and fixed_q are written through the cfg port; the user
// must write them only while the block is idle, the block itself does not
// enforce it.
// ----------------------------------------------------------------------------
module eq_preset_string_parser #(
	parameter int unsigned FIXED_BAND_COUNT = eps_pkg::FIXED_BAND_COUNT_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// slave side: character stream
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [eps_pkg::CHAR_W-1:0]     s_tdata,    // char_code
	input  wire logic                           s_tlast,    // line_end
	// master side: results
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	// band_type, freq_milli_hz, gain_milli_db, q_milli, line_accepted, zero fill
	output logic [eps_pkg::TDATA_W-1:0]         m_tdata,
	output logic [1:0]                          m_tuser,    // result_kind
	output logic                                m_tlast,    // last_of_run
	// configuration writes
	input  wire logic                           cfg_we,
	input  wire logic [eps_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [eps_pkg::Q_W-1:0]        cfg_data
);
	import eps_pkg::*;

	localparam logic [OQ_CNT_W-1:0] OQ_ROOM_MAX = OQ_CNT_W'(OQ_DEPTH - 2);

	// configuration registers
	logic [Q_W-1:0] default_q_q;
	logic [Q_W-1:0] fixed_q_q;

	// input register
	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              end_s1;

	// output queue
	result_t               oq_mem [OQ_DEPTH];
	logic [OQ_PTR_W-1:0]   wr_ptr_q;
	logic [OQ_PTR_W-1:0]   wr_ptr_nx;
	logic [OQ_PTR_W-1:0]   rd_ptr_q;
	logic [OQ_CNT_W-1:0]   count_q;
	logic [1:0]            push_n;
	logic                  pop;
	logic                  room;
	logic                  advance;
	result_t               head;

	pair_t core_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			default_q_q <= DEFAULT_Q_RST;
			fixed_q_q   <= FIXED_Q_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_DEFAULT_Q: default_q_q <= cfg_data;
				CFG_FIXED_Q:   fixed_q_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// the held character is parsed only when the queue can take two results
	assign room     = (count_q <= OQ_ROOM_MAX);
	assign advance  = valid_s1 && room;
	assign s_tready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	eps_core #(
		.FIXED_BAND_COUNT (FIXED_BAND_COUNT)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.char_code (char_s1),
		.line_end  (end_s1),
		.default_q (default_q_q),
		.fixed_q   (fixed_q_q),
		.results   (core_res)
	);

	// queue write: number result first, then status
	assign wr_ptr_nx = wr_ptr_q + 1'b1;
	assign push_n    = {1'b0, core_res.a_valid} + {1'b0, core_res.b_valid};
	assign pop       = m_tvalid && m_tready;

	always_ff @(posedge clk) begin
		if (core_res.a_valid && core_res.b_valid) begin
			oq_mem[wr_ptr_q]  <= core_res.a;
			oq_mem[wr_ptr_nx] <= core_res.b;
		end else if (core_res.a_valid) begin
			oq_mem[wr_ptr_q] <= core_res.a;
		end else if (core_res.b_valid) begin
			oq_mem[wr_ptr_q] <= core_res.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + OQ_PTR_W'(push_n);
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			count_q <= count_q + OQ_CNT_W'(push_n) - OQ_CNT_W'(pop);
		end
	end

	// master side driven from the queue head
	assign head     = oq_mem[rd_ptr_q];
	assign m_tvalid = (count_q != '0);
	assign m_tuser  = head.kind;
	assign m_tlast  = head.last;
	assign m_tdata  = {{(TDATA_W - TYPE_W - FREQ_W - GAIN_W - Q_W - 1){1'b0}},
		head.accepted, head.q, head.gain, head.freq, head.band_type};

endmodule
`default_nettype wire
